// ===== design/rbd_pkg.sv =====
// rbd_pkg: shared types and constants for the run-length block decoder.
// No dependencies; compiled first.
package rbd_pkg;

   // Decoder phase codes
   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_CTRL_LO = 3'd1,
      PH_CTRL_HI = 3'd2,
      PH_LITERAL = 3'd3,
      PH_FILL    = 3'd4
   } phase_type;

   localparam int unsigned HDR_SKIP_BYTES = 4;   // packed-length word, skipped
   localparam int unsigned HDR_LAST_INDEX = 7;   // last byte of the declared length

   localparam logic [15:0] COUNT_MASK   = 16'h7fff;
   localparam logic [15:0] LITERAL_FLAG = 16'h8000;

   // Registered input byte
   typedef struct packed {
      logic       valid;
      logic [7:0] in_byte;
   } in_stage_type;

   // One decoded result
   typedef struct packed {
      logic [7:0]  byte_value;
      logic [15:0] repeat_count;
      logic        stream_done;
      logic        overrun;
   } rsp_type;

   // Result from the decode step plus its valid flag
   typedef struct packed {
      logic    valid;
      rsp_type payload;
   } result_type;

endpackage

// ===== design/rbd_if.sv =====
// rbd_if: valid/ready channel interfaces for the request and response sides.
// No package dependencies.
interface rbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface rbd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  byte_value;
   logic [15:0] repeat_count;
   logic        stream_done;
   logic        overrun;

   modport source (output valid, output byte_value, output repeat_count,
                   output stream_done, output overrun, input ready);
   modport sink   (input valid, input byte_value, input repeat_count,
                   input stream_done, input overrun, output ready);
endinterface

// ===== design/rle_block_decoder_core.sv =====
// Run-length block decoder: one compressed byte in, at most one run result out.
// Path: input register, combinational decode, result register.
// Throughput: one byte per cycle, limited only by response-side backpressure.
// Reset (synchronous): header phase, zero length/counters, both stages empty.
// Depends on rbd_pkg, rbd_if, rbd_in_stage, rbd_decode, rbd_out_stage.
module rle_block_decoder_core (
   input  logic      clock,
   input  logic      reset,
   rbd_req_if.sink   req_ch,
   rbd_rsp_if.source rsp_ch
);
   import rbd_pkg::*;

   in_stage_type stage;
   result_type   result;
   logic         out_free;
   logic         advance;

   // Held byte is decoded when the result register can take its output
   assign advance = stage.valid && out_free;

   rbd_in_stage u_in_stage (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .advance (advance),
      .stage   (stage)
   );

   rbd_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .in_byte (stage.in_byte),
      .result  (result)
   );

   rbd_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .result   (result),
      .out_free (out_free),
      .rsp_ch   (rsp_ch)
   );

endmodule

// ===== design/rbd_in_stage.sv =====
// rbd_in_stage: input register for the compressed byte stream.
// Depends on rbd_pkg and rbd_req_if.
module rbd_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   rbd_req_if.sink               req_ch,
   input  logic                  advance,
   output rbd_pkg::in_stage_type stage
);
   import rbd_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       take;

   // Room when empty or when the held byte moves on this cycle
   assign req_ch.ready = !valid_ff || advance;
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (take) begin
         valid_in = 1'b1;
         byte_in  = req_ch.in_byte;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign stage.valid   = valid_ff;
   assign stage.in_byte = byte_ff;

endmodule

// ===== design/rbd_decode.sv =====
// rbd_decode: header/control parsing state and result generation, one byte per step.
// Depends on rbd_pkg.
module rbd_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          in_byte,
   output rbd_pkg::result_type result
);
   import rbd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [2:0]  hdr_idx_ff, hdr_idx_in;
   logic [31:0] remaining_ff, remaining_in;
   logic [7:0]  ctrl_lo_ff, ctrl_lo_in;
   logic [15:0] run_left_ff, run_left_in;

   logic [31:0] rem_dec;
   logic [15:0] run_dec;
   logic [15:0] ctrl_word;
   logic [31:0] fill_rem;
   logic [15:0] fill_rep;
   logic        fill_over;

   assign rem_dec   = remaining_ff - 32'd1;
   assign run_dec   = run_left_ff - 16'd1;
   assign ctrl_word = {in_byte, ctrl_lo_ff};

   // Fill run clipped to what is left of the declared length
   assign fill_over = {16'd0, run_left_ff} > remaining_ff;
   assign fill_rep  = fill_over ? remaining_ff[15:0] : run_left_ff;
   assign fill_rem  = remaining_ff - {16'd0, fill_rep};

   always_comb begin
      phase_in     = phase_ff;
      hdr_idx_in   = hdr_idx_ff;
      remaining_in = remaining_ff;
      ctrl_lo_in   = ctrl_lo_ff;
      run_left_in  = run_left_ff;
      result       = '0;

      unique case (phase_ff)
         PH_CTRL_LO: begin
            ctrl_lo_in = in_byte;
            phase_in   = PH_CTRL_HI;
         end
         PH_CTRL_HI: begin
            run_left_in = (ctrl_word & COUNT_MASK) + 16'd1;
            phase_in    = ((ctrl_word & LITERAL_FLAG) != 16'd0) ? PH_LITERAL : PH_FILL;
         end
         PH_LITERAL: begin
            remaining_in                 = rem_dec;
            run_left_in                  = run_dec;
            result.valid                 = 1'b1;
            result.payload.byte_value    = in_byte;
            result.payload.repeat_count  = 16'd1;
            if (rem_dec == 32'd0) begin
               result.payload.stream_done = 1'b1;
               result.payload.overrun     = (run_dec != 16'd0);
               run_left_in                = 16'd0;
               phase_in                   = PH_HEADER;
               hdr_idx_in                 = 3'd0;
            end else if (run_dec == 16'd0) begin
               phase_in = PH_CTRL_LO;
            end
         end
         PH_FILL: begin
            remaining_in                = fill_rem;
            run_left_in                 = 16'd0;
            result.valid                = 1'b1;
            result.payload.byte_value   = in_byte;
            result.payload.repeat_count = fill_rep;
            result.payload.overrun      = fill_over;
            if (fill_rem == 32'd0) begin
               result.payload.stream_done = 1'b1;
               phase_in                   = PH_HEADER;
               hdr_idx_in                 = 3'd0;
            end else begin
               phase_in = PH_CTRL_LO;
            end
         end
         default: begin
            // Header: skip packed-length word, then gather declared length LSB first
            if (hdr_idx_ff < 3'(HDR_SKIP_BYTES)) begin
               hdr_idx_in = hdr_idx_ff + 3'd1;
            end else begin
               unique case (hdr_idx_ff[1:0])
                  2'd0: remaining_in = {24'd0, in_byte};
                  2'd1: remaining_in = remaining_ff | {16'd0, in_byte, 8'd0};
                  2'd2: remaining_in = remaining_ff | {8'd0, in_byte, 16'd0};
                  default: remaining_in = remaining_ff | {in_byte, 24'd0};
               endcase
               if (hdr_idx_ff < 3'(HDR_LAST_INDEX)) begin
                  hdr_idx_in = hdr_idx_ff + 3'd1;
               end else begin
                  hdr_idx_in = 3'd0;
                  if (remaining_in == 32'd0) begin
                     // empty stream: single done result with zero repeat
                     result.valid               = 1'b1;
                     result.payload.stream_done = 1'b1;
                  end else begin
                     phase_in = PH_CTRL_LO;
                  end
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         hdr_idx_ff   <= 3'd0;
         remaining_ff <= 32'd0;
         ctrl_lo_ff   <= 8'd0;
         run_left_ff  <= 16'd0;
      end else if (step) begin
         phase_ff     <= phase_in;
         hdr_idx_ff   <= hdr_idx_in;
         remaining_ff <= remaining_in;
         ctrl_lo_ff   <= ctrl_lo_in;
         run_left_ff  <= run_left_in;
      end
   end

endmodule

// ===== design/rbd_out_stage.sv =====
// rbd_out_stage: result register driving the response channel.
// Depends on rbd_pkg and rbd_rsp_if.
module rbd_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  rbd_pkg::result_type result,
   output logic                out_free,
   rbd_rsp_if.source           rsp_ch
);
   import rbd_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;
   logic    load;

   assign out_free = !valid_ff || rsp_ch.ready;
   assign load     = step && result.valid;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result.payload;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.byte_value   = data_ff.byte_value;
   assign rsp_ch.repeat_count = data_ff.repeat_count;
   assign rsp_ch.stream_done  = data_ff.stream_done;
   assign rsp_ch.overrun      = data_ff.overrun;

endmodule

// ===== design/rbd_checker.sv =====
// rbd_checker: port-level checks on the decoder's response channel, bound to the top.
// Depends on rle_block_decoder_core.
module rbd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  byte_value,
   input logic [15:0] repeat_count,
   input logic        stream_done,
   input logic        overrun
);

   // Nothing offered right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Zero repeat only for an empty stream, which is a clean done with byte 0
   a_zero_rep: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && repeat_count == 16'd0) |-> (stream_done && !overrun && byte_value == 8'd0))
      else $error("zero repeat on a non-empty-stream result");

   // An overrun always ends the stream
   a_overrun_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && overrun) |-> stream_done)
      else $error("overrun without stream_done");

   // A run never exceeds 15-bit count plus one
   a_rep_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (repeat_count <= 16'h8000))
      else $error("repeat_count out of range");

   // Stalled transaction holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(byte_value)
                                     && $stable(repeat_count) && $stable(stream_done)
                                     && $stable(overrun)))
      else $error("stalled response changed");

endmodule

bind rle_block_decoder_core rbd_checker u_rbd_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .byte_value   (rsp_ch.byte_value),
   .repeat_count (rsp_ch.repeat_count),
   .stream_done  (rsp_ch.stream_done),
   .overrun      (rsp_ch.overrun)
);
